@@ src/poly_eval_residual_norm_core_macros.svh @@
`ifndef POLY_EVAL_RESIDUAL_NORM_CORE_MACROS_SVH
`define POLY_EVAL_RESIDUAL_NORM_CORE_MACROS_SVH

`ifndef SYNTHESIS

// property holds at every clock edge outside reset
`define PERN_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define PERN_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define PERN_ASSERT(lbl, clk, rst, prop, msg)
`define PERN_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

@@ src/pern_pkg.sv @@
`timescale 1ns / 1ps

package pern_pkg;

   localparam int DATA_W      = 32;
   localparam int OP_W        = 33;
   localparam int PROD_W      = 66;
   localparam int ACC_W       = 64;
   localparam int REM_W       = 36;
   localparam int NUM_W       = 3;
   localparam int CSR_IDX_W   = 8;
   localparam int SQRT_CNT_W  = 5;

   localparam logic [SQRT_CNT_W-1:0] SQRT_LAST_STEP = '1;

   localparam logic [CSR_IDX_W-1:0] REG_NUM_COEFFS = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_COEFF_0    = CSR_IDX_W'(1);

   localparam logic signed [PROD_W-1:0] SAT_MAX = PROD_W'(64'sd2147483647);
   localparam logic signed [PROD_W-1:0] SAT_MIN = ~SAT_MAX;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_H_MUL,
      ST_H_ADD,
      ST_DIFF,
      ST_SQ_MUL,
      ST_ACC,
      ST_SQRT
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } sqrt_status_type;

   typedef struct packed {
      logic load_item;
      logic mul_en;
      logic mul_square;
      logic horner_step;
      logic diff_step;
      logic acc_step;
      logic sqrt_start;
      logic rsp_norm;
   } ctrl_type;

endpackage

@@ src/pern_mult.sv @@
`timescale 1ns / 1ps

module pern_mult (
   input  logic                                  clock,
   input  logic                                  enable,
   input  logic signed [pern_pkg::OP_W-1:0]      op_a,
   input  logic signed [pern_pkg::OP_W-1:0]      op_b,
   output logic signed [pern_pkg::PROD_W-1:0]    product
);

   logic signed [pern_pkg::PROD_W-1:0] product_ff;
   logic signed [pern_pkg::PROD_W-1:0] product_in;

   always_comb begin
      product_in = op_a * op_b;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         product_ff <= product_in;
      end
   end

   assign product = product_ff;

endmodule

@@ src/pern_isqrt.sv @@
`timescale 1ns / 1ps
`include "poly_eval_residual_norm_core_macros.svh"

module pern_isqrt (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [pern_pkg::ACC_W-1:0]          value,
   output logic [pern_pkg::DATA_W-1:0]         root,
   output pern_pkg::sqrt_status_type           status
);

   logic [pern_pkg::ACC_W-1:0]      val_ff, val_in;
   logic [pern_pkg::REM_W-1:0]      rem_ff, rem_in;
   logic [pern_pkg::DATA_W-1:0]     root_ff, root_in;
   logic [pern_pkg::SQRT_CNT_W-1:0] cnt_ff, cnt_in;
   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;

   logic [pern_pkg::REM_W-1:0]      rem_sh;
   logic [pern_pkg::REM_W-1:0]      trial;
   logic                            fits;

   // one root bit per step
   always_comb begin
      rem_sh = {rem_ff[pern_pkg::REM_W-3:0], val_ff[pern_pkg::ACC_W-1 -: 2]};
      trial  = {2'b00, root_ff, 2'b01};
      fits   = (rem_sh >= trial);

      val_in  = val_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = busy_ff && (cnt_ff == pern_pkg::SQRT_LAST_STEP);

      if (start) begin
         val_in  = value;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         val_in  = {val_ff[pern_pkg::ACC_W-3:0], 2'b00};
         rem_in  = fits ? (rem_sh - trial) : rem_sh;
         root_in = {root_ff[pern_pkg::DATA_W-2:0], fits};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == pern_pkg::SQRT_LAST_STEP) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign root        = root_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

   `PERN_ASSERT_NEXT(a_start_busy, clock, reset, start, busy_ff, "sqrt did not start")
   `PERN_ASSERT(a_done_idle, clock, reset, done_ff |-> !busy_ff, "sqrt done while busy")
   `PERN_ASSERT_NEXT(a_done_pulse, clock, reset, done_ff && !start, !done_ff, "sqrt done held")

endmodule

@@ src/poly_eval_residual_norm_core.sv @@
`timescale 1ns / 1ps
`include "poly_eval_residual_norm_core_macros.svh"

// per point: multiply and add per coefficient in use, then difference, square and accumulate
// a point flagged last then runs the 32-step bit-serial square root before its result is strobed
// a new point is accepted only when idle; the shared multiplier serves both Horner and squaring
// results are strobed for one cycle; the receiver cannot stall them
// synchronous reset clears the state, configuration, error accumulator and sticky overflow flag

module poly_eval_residual_norm_core #(
   parameter int MAX_COEFFS = 6,
   parameter int FRAC_BITS  = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [pern_pkg::DATA_W-1:0]    req_sample_x,
   input  logic signed [pern_pkg::DATA_W-1:0]    req_sample_y,
   input  logic                                  req_last_sample,
   output logic                                  rsp_strobe,
   output logic signed [pern_pkg::DATA_W-1:0]    rsp_poly_value,
   output logic [pern_pkg::DATA_W-1:0]           rsp_residual_norm,
   output logic                                  rsp_done_res,
   output logic                                  rsp_overflow,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [pern_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [pern_pkg::DATA_W-1:0]           csr_wdata
);

   localparam int CNT_W = $clog2(MAX_COEFFS + 1);
   localparam int IDX_W = (MAX_COEFFS > 1) ? $clog2(MAX_COEFFS) : 1;

   pern_pkg::state_type state_ff, state_in;
   pern_pkg::ctrl_type  ctrl;
   pern_pkg::sqrt_status_type sqrt_stat;

   logic [pern_pkg::NUM_W-1:0]           num_coeffs_ff;
   logic signed [pern_pkg::DATA_W-1:0]   coeff_ff [MAX_COEFFS];

   logic signed [pern_pkg::DATA_W-1:0]   x_ff, y_ff;
   logic                                 last_ff;
   logic [CNT_W-1:0]                     k_ff, k_in;
   logic signed [pern_pkg::DATA_W-1:0]   acc_ff, acc_in;
   logic                                 item_ovf_ff, item_ovf_in;
   logic [pern_pkg::DATA_W-1:0]          mag_ff;
   logic [pern_pkg::ACC_W-1:0]           err_ff, err_in;
   logic                                 seen_ff, seen_in;

   logic                                 rsp_strobe_ff, rsp_strobe_in;
   logic signed [pern_pkg::DATA_W-1:0]   rsp_poly_value_ff;
   logic [pern_pkg::DATA_W-1:0]          rsp_residual_norm_ff;
   logic                                 rsp_done_res_ff;
   logic                                 rsp_overflow_ff;

   logic                                 accept;
   logic [CNT_W-1:0]                     n_clamp;
   logic [CNT_W-1:0]                     k_m1;
   logic signed [pern_pkg::DATA_W-1:0]   coeff_sel;
   logic signed [pern_pkg::OP_W-1:0]     mul_a, mul_b;
   logic signed [pern_pkg::PROD_W-1:0]   product;
   logic signed [pern_pkg::PROD_W-1:0]   coeff_ext, sum_full, sum_shift;
   logic signed [pern_pkg::DATA_W-1:0]   horner_val;
   logic                                 horner_sat;
   logic signed [pern_pkg::DATA_W:0]     diff, diff_neg;
   logic [pern_pkg::DATA_W-1:0]          mag;
   logic [pern_pkg::ACC_W:0]             err_sum;
   logic [pern_pkg::ACC_W-1:0]           err_new;
   logic                                 ovf_all;
   logic [pern_pkg::DATA_W-1:0]          sqrt_root;

   assign accept    = start && !busy;
   assign busy      = (state_ff != pern_pkg::ST_IDLE);
   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         num_coeffs_ff <= '0;
         for (int i = 0; i < MAX_COEFFS; i++) begin
            coeff_ff[i] <= '0;
         end
      end else if (csr_valid && csr_ready) begin
         if (csr_index == pern_pkg::REG_NUM_COEFFS) begin
            num_coeffs_ff <= csr_wdata[pern_pkg::NUM_W-1:0];
         end
         for (int i = 0; i < MAX_COEFFS; i++) begin
            if (csr_index == pern_pkg::REG_COEFF_0 + pern_pkg::CSR_IDX_W'(i)) begin
               coeff_ff[i] <= csr_wdata;
            end
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pern_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = (n_clamp == '0) ? pern_pkg::ST_DIFF : pern_pkg::ST_H_MUL;
            end
         end
         pern_pkg::ST_H_MUL: begin
            state_in = pern_pkg::ST_H_ADD;
         end
         pern_pkg::ST_H_ADD: begin
            state_in = (k_ff == CNT_W'(1)) ? pern_pkg::ST_DIFF : pern_pkg::ST_H_MUL;
         end
         pern_pkg::ST_DIFF: begin
            state_in = pern_pkg::ST_SQ_MUL;
         end
         pern_pkg::ST_SQ_MUL: begin
            state_in = pern_pkg::ST_ACC;
         end
         pern_pkg::ST_ACC: begin
            state_in = last_ff ? pern_pkg::ST_SQRT : pern_pkg::ST_IDLE;
         end
         pern_pkg::ST_SQRT: begin
            if (sqrt_stat.done) begin
               state_in = pern_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pern_pkg::ST_IDLE;
         end
      endcase
   end

   // control decode
   always_comb begin
      ctrl = '0;
      unique case (state_ff)
         pern_pkg::ST_IDLE: begin
            ctrl.load_item = accept;
         end
         pern_pkg::ST_H_MUL: begin
            ctrl.mul_en = 1'b1;
         end
         pern_pkg::ST_H_ADD: begin
            ctrl.horner_step = 1'b1;
         end
         pern_pkg::ST_DIFF: begin
            ctrl.diff_step = 1'b1;
         end
         pern_pkg::ST_SQ_MUL: begin
            ctrl.mul_en     = 1'b1;
            ctrl.mul_square = 1'b1;
         end
         pern_pkg::ST_ACC: begin
            ctrl.acc_step   = 1'b1;
            ctrl.sqrt_start = last_ff;
         end
         pern_pkg::ST_SQRT: begin
            ctrl.rsp_norm = sqrt_stat.done;
         end
         default: begin
            ctrl = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pern_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath
   always_comb begin
      n_clamp = (num_coeffs_ff > pern_pkg::NUM_W'(MAX_COEFFS)) ? CNT_W'(MAX_COEFFS)
                                                             : CNT_W'(num_coeffs_ff);
      k_m1      = k_ff - 1'b1;
      coeff_sel = coeff_ff[k_m1[IDX_W-1:0]];

      mul_a = ctrl.mul_square ? $signed({1'b0, mag_ff}) : $signed({acc_ff[pern_pkg::DATA_W-1], acc_ff});
      mul_b = ctrl.mul_square ? $signed({1'b0, mag_ff}) : $signed({x_ff[pern_pkg::DATA_W-1], x_ff});

      // horner step: floor((acc*x + c*2^f) / 2^f), saturated
      coeff_ext = pern_pkg::PROD_W'(coeff_sel) <<< FRAC_BITS;
      sum_full  = product + coeff_ext;
      sum_shift = sum_full >>> FRAC_BITS;
      horner_sat = 1'b0;
      if (sum_shift > pern_pkg::SAT_MAX) begin
         horner_val = pern_pkg::SAT_MAX[pern_pkg::DATA_W-1:0];
         horner_sat = 1'b1;
      end else if (sum_shift < pern_pkg::SAT_MIN) begin
         horner_val = pern_pkg::SAT_MIN[pern_pkg::DATA_W-1:0];
         horner_sat = 1'b1;
      end else begin
         horner_val = sum_shift[pern_pkg::DATA_W-1:0];
      end

      diff     = $signed({y_ff[pern_pkg::DATA_W-1], y_ff}) - $signed({acc_ff[pern_pkg::DATA_W-1], acc_ff});
      diff_neg = -diff;
      mag      = diff[pern_pkg::DATA_W] ? diff_neg[pern_pkg::DATA_W-1:0] : diff[pern_pkg::DATA_W-1:0];

      err_sum = {1'b0, err_ff} + {1'b0, product[pern_pkg::ACC_W-1:0]};
      err_new = err_sum[pern_pkg::ACC_W] ? '1 : err_sum[pern_pkg::ACC_W-1:0];
      ovf_all = seen_ff || item_ovf_ff || err_sum[pern_pkg::ACC_W];

      k_in        = k_ff;
      acc_in      = acc_ff;
      item_ovf_in = item_ovf_ff;
      err_in      = err_ff;
      seen_in     = seen_ff;
      if (ctrl.load_item) begin
         k_in        = n_clamp;
         acc_in      = '0;
         item_ovf_in = 1'b0;
      end
      if (ctrl.horner_step) begin
         k_in        = k_m1;
         acc_in      = horner_val;
         item_ovf_in = item_ovf_ff || horner_sat;
      end
      if (ctrl.acc_step) begin
         err_in  = last_ff ? '0 : err_new;
         seen_in = last_ff ? 1'b0 : ovf_all;
      end

      rsp_strobe_in = (ctrl.acc_step && !last_ff) || ctrl.rsp_norm;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         err_ff        <= '0;
         seen_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         err_ff        <= err_in;
         seen_ff       <= seen_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_item) begin
         x_ff    <= req_sample_x;
         y_ff    <= req_sample_y;
         last_ff <= req_last_sample;
      end
      if (ctrl.diff_step) begin
         mag_ff <= mag;
      end
      k_ff        <= k_in;
      acc_ff      <= acc_in;
      item_ovf_ff <= item_ovf_in;
      if (ctrl.acc_step) begin
         rsp_poly_value_ff    <= acc_ff;
         rsp_overflow_ff      <= ovf_all;
         rsp_done_res_ff      <= last_ff;
         rsp_residual_norm_ff <= '0;
      end
      if (ctrl.rsp_norm) begin
         rsp_residual_norm_ff <= sqrt_root;
      end
   end

   pern_mult u_mult (
      .clock   (clock),
      .enable  (ctrl.mul_en),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (product)
   );

   pern_isqrt u_isqrt (
      .clock  (clock),
      .reset  (reset),
      .start  (ctrl.sqrt_start),
      .value  (err_new),
      .root   (sqrt_root),
      .status (sqrt_stat)
   );

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_poly_value    = rsp_poly_value_ff;
   assign rsp_residual_norm = rsp_residual_norm_ff;
   assign rsp_done_res      = rsp_done_res_ff;
   assign rsp_overflow      = rsp_overflow_ff;

   `PERN_ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy, "item transfer did not start work")
   `PERN_ASSERT_NEXT(a_strobe_pulse, clock, reset, rsp_strobe_ff, !rsp_strobe_ff, "result strobe held")
   `PERN_ASSERT(a_norm_zero, clock, reset, (rsp_strobe_ff && !rsp_done_res_ff) |-> (rsp_residual_norm_ff == '0), "norm set on a point that is not last")
   `PERN_ASSERT(a_sqrt_wait, clock, reset, (state_ff == pern_pkg::ST_SQRT) |-> (sqrt_stat.busy || sqrt_stat.done), "waiting on an idle square root unit")

endmodule
